// ----- rtl/core/lbac_pkg.sv -----
`timescale 1ns / 1ps

package lbac_pkg;

    localparam int HEADS_W     = 8;
    localparam int SPT_W       = 6;
    localparam int PER_CYL_W   = 14;   // 255 * 63 = 16065 fits in 14 bits
    localparam int CYL_W       = 16;
    localparam int ADDR_PORT_W = 32;
    localparam int ADDR_BITS_DEFAULT = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Quotient bits resolved per divider stage.
    localparam int DIV_STEPS = 4;

    localparam logic [HEADS_W-1:0] HEADS_RESET = 8'd16;
    localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADS = 1'b0,
        REG_SPT   = 1'b1
    } t_cfg_reg;

endpackage

// ----- rtl/core/lbac_div_pipe.sv -----
`timescale 1ns / 1ps

module lbac_div_pipe
    import lbac_pkg::*;
#(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 14,
    parameter int SIDE_W     = 6,
    parameter int STEPS      = DIV_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder,
    output logic [DIVISOR_W-1:0]  o_divisor,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int NSTAGE = (DIVIDEND_W + STEPS - 1) / STEPS;

    logic                  r_valid [NSTAGE];
    logic [DIVISOR_W-1:0]  r_rem   [NSTAGE];
    logic [DIVIDEND_W-1:0] r_dq    [NSTAGE];
    logic [DIVISOR_W-1:0]  r_div   [NSTAGE];
    logic [SIDE_W-1:0]     r_side  [NSTAGE];

    genvar s;
    generate
        for (s = 0; s < NSTAGE; s++) begin : g_stage
            logic                  in_valid;
            logic [DIVISOR_W-1:0]  in_rem;
            logic [DIVIDEND_W-1:0] in_dq;
            logic [DIVISOR_W-1:0]  in_div;
            logic [SIDE_W-1:0]     in_side;
            logic [DIVISOR_W-1:0]  n_rem;
            logic [DIVIDEND_W-1:0] n_dq;

            if (s == 0) begin : g_first
                assign in_valid = i_valid;
                assign in_rem   = '0;
                assign in_dq    = i_dividend;
                assign in_div   = i_divisor;
                assign in_side  = i_side;
            end else begin : g_next
                assign in_valid = r_valid[s-1];
                assign in_rem   = r_rem[s-1];
                assign in_dq    = r_dq[s-1];
                assign in_div   = r_div[s-1];
                assign in_side  = r_side[s-1];
            end

            // The word holds the dividend bits still to be consumed at the top and
            // the quotient bits already produced at the bottom.
            always_comb begin : p_steps
                logic [DIVISOR_W:0] trial;
                n_rem = in_rem;
                n_dq  = in_dq;
                trial = '0;
                for (int k = 0; k < STEPS; k++) begin
                    if (s * STEPS + k < DIVIDEND_W) begin
                        trial = {n_rem, n_dq[DIVIDEND_W-1]};
                        n_dq  = {n_dq[DIVIDEND_W-2:0], 1'b0};
                        if (trial >= {1'b0, in_div}) begin
                            n_rem   = DIVISOR_W'(trial - {1'b0, in_div});
                            n_dq[0] = 1'b1;
                        end else begin
                            n_rem = trial[DIVISOR_W-1:0];
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[s] <= 1'b0;
                end else begin
                    r_valid[s] <= in_valid;
                end
                r_rem[s]  <= n_rem;
                r_dq[s]   <= n_dq;
                r_div[s]  <= in_div;
                r_side[s] <= in_side;
            end
        end
    endgenerate

    assign o_valid     = r_valid[NSTAGE-1];
    assign o_quotient  = r_dq[NSTAGE-1];
    assign o_remainder = r_rem[NSTAGE-1];
    assign o_divisor   = r_div[NSTAGE-1];
    assign o_side      = r_side[NSTAGE-1];

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_divisor != '0)) |-> (o_remainder < o_divisor))
        else $error("divider remainder not below its divisor");

    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, NSTAGE))
        else $error("divider output valid without a matching request");

    a_valid_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(o_valid))
        else $error("divider output valid is unknown");

endmodule

// ----- rtl/core/lba_to_chs_converter.sv -----
`timescale 1ns / 1ps

// Converts a logical block address into cylinder, head and sector numbers.
//
// Requests: a request is taken at every rising edge with start high; busy is
// always low, so a new address may be presented in every cycle.
// Results: each result appears on the o_ ports for one cycle, marked by
// o_result_valid, in request order. The receiver cannot hold results off.
// Pipeline: the input register, the sectors-per-cylinder register, the two
// restoring dividers, each stage of which resolves four quotient bits, and
// the output register. Throughput is one request per cycle.
// Geometry: heads and sectors per track are written through the i_cfg_ port
// by the user only while no request is in flight; the block does not enforce
// this. A zero value is taken as one. The geometry is captured with each
// request and travels with it. Reset: the pipeline is emptied and the
// geometry returns to 16 heads and 63 sectors per track.
// The cylinder keeps the low 16 bits of the quotient; o_cylinder_overflow
// marks a quotient that did not fit.
module lba_to_chs_converter
    import lbac_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ADDR_PORT_W-1:0] i_block_address,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_result_valid,
    output logic [CYL_W-1:0]       o_cylinder_number,
    output logic [HEADS_W-1:0]     o_head_number,
    output logic [SPT_W-1:0]       o_sector_number,
    output logic                   o_cylinder_overflow
);

    localparam int DIV1_STAGES = (ADDRESS_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV2_STAGES = (PER_CYL_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int LATENCY     = 3 + DIV1_STAGES + DIV2_STAGES;

    logic [HEADS_W-1:0]      r_heads;
    logic [SPT_W-1:0]        r_spt;

    logic                    r_in_valid;
    logic [ADDRESS_BITS-1:0] r_in_addr;
    logic [HEADS_W-1:0]      r_in_heads;
    logic [SPT_W-1:0]        r_in_spt;

    logic                    r_m_valid;
    logic [ADDRESS_BITS-1:0] r_m_addr;
    logic [PER_CYL_W-1:0]    r_m_per_cyl;
    logic [SPT_W-1:0]        r_m_spt;

    logic                    q1_valid;
    logic [ADDRESS_BITS-1:0] q1_quot;
    logic [PER_CYL_W-1:0]    q1_rem;
    logic [PER_CYL_W-1:0]    q1_div;
    logic [SPT_W-1:0]        q1_spt;

    logic                    q2_valid;
    logic [PER_CYL_W-1:0]    q2_quot;
    logic [PER_CYL_W-1:0]    q2_rem;
    logic [PER_CYL_W-1:0]    q2_div;
    logic [ADDRESS_BITS-1:0] q2_cyl;

    logic                    n_overflow;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads <= HEADS_RESET;
            r_spt   <= SPT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_HEADS: r_heads <= i_cfg_data[HEADS_W-1:0];
                REG_SPT:   r_spt   <= i_cfg_data[SPT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Input stage: capture the address and the geometry, with zero taken as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_in_addr  <= i_block_address[ADDRESS_BITS-1:0];
        r_in_heads <= (r_heads == '0) ? HEADS_W'(1) : r_heads;
        r_in_spt   <= (r_spt == '0) ? SPT_W'(1) : r_spt;
    end

    // Sectors per cylinder, registered before it feeds the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= r_in_valid;
        end
        r_m_addr    <= r_in_addr;
        r_m_per_cyl <= PER_CYL_W'(PER_CYL_W'(r_in_heads) * PER_CYL_W'(r_in_spt));
        r_m_spt     <= r_in_spt;
    end

    lbac_div_pipe #(
        .DIVIDEND_W (ADDRESS_BITS),
        .DIVISOR_W  (PER_CYL_W),
        .SIDE_W     (SPT_W),
        .STEPS      (DIV_STEPS)
    ) u_cyl_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_m_valid),
        .i_dividend  (r_m_addr),
        .i_divisor   (r_m_per_cyl),
        .i_side      (r_m_spt),
        .o_valid     (q1_valid),
        .o_quotient  (q1_quot),
        .o_remainder (q1_rem),
        .o_divisor   (q1_div),
        .o_side      (q1_spt)
    );

    lbac_div_pipe #(
        .DIVIDEND_W (PER_CYL_W),
        .DIVISOR_W  (PER_CYL_W),
        .SIDE_W     (ADDRESS_BITS),
        .STEPS      (DIV_STEPS)
    ) u_head_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q1_valid && (q1_div != '0)),
        .i_dividend  (q1_rem),
        .i_divisor   (PER_CYL_W'(q1_spt)),
        .i_side      (q1_quot),
        .o_valid     (q2_valid),
        .o_quotient  (q2_quot),
        .o_remainder (q2_rem),
        .o_divisor   (q2_div),
        .o_side      (q2_cyl)
    );

    generate
        if (ADDRESS_BITS > CYL_W) begin : g_ovf
            assign n_overflow = |q2_cyl[ADDRESS_BITS-1:CYL_W];
        end else begin : g_no_ovf
            assign n_overflow = 1'b0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= q2_valid;
        end
        o_cylinder_number   <= q2_cyl[CYL_W-1:0];
        o_head_number       <= q2_quot[HEADS_W-1:0];
        o_sector_number     <= SPT_W'(q2_rem[SPT_W-1:0] + SPT_W'(1));
        o_cylinder_overflow <= n_overflow;
    end

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start, LATENCY))
        else $error("result without a request at the expected latency");

    a_sector_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_sector_number != '0))
        else $error("sector number is zero");

    a_head_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q2_valid && (q2_div != '0)) |-> (q2_quot[PER_CYL_W-1:HEADS_W] == '0))
        else $error("head quotient does not fit in eight bits");

endmodule

// ----- bench/lba_to_chs_converter_tb.sv -----
`timescale 1ns / 1ps

module lba_to_chs_converter_tb;
    import lbac_pkg::*;

    localparam int LBA_BITS = ADDR_BITS_DEFAULT;

    typedef struct packed {
        logic [CYL_W-1:0]   cylinder;
        logic [HEADS_W-1:0] head;
        logic [SPT_W-1:0]   sector;
        logic               overflow;
    } t_chs;

    // One entry of the stimulus plan: either an address request or a geometry write.
    typedef struct {
        bit                    is_geometry;
        t_cfg_reg              reg_sel;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [ADDR_PORT_W-1:0] lba;
        int                    idle_pct;
    } t_lba_request;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [ADDR_PORT_W-1:0]  i_block_address = '0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    o_result_valid;
    logic [CYL_W-1:0]        o_cylinder_number;
    logic [HEADS_W-1:0]      o_head_number;
    logic [SPT_W-1:0]        o_sector_number;
    logic                    o_cylinder_overflow;

    t_lba_request lba_requests[$];
    t_chs         chs_expected[$];

    logic [HEADS_W-1:0] model_heads = HEADS_RESET;
    logic [SPT_W-1:0]   model_spt = SPT_RESET;
    logic               request_taken = 1'b0;
    bit                 mismatch_seen = 1'b0;

    lba_to_chs_converter #(
        .ADDRESS_BITS(LBA_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_block_address(i_block_address),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid),
        .o_cylinder_number(o_cylinder_number),
        .o_head_number(o_head_number),
        .o_sector_number(o_sector_number),
        .o_cylinder_overflow(o_cylinder_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned geometry_divisor(longint unsigned raw);
        return (raw == 0) ? 1 : raw;
    endfunction

    function automatic t_chs lba_to_chs(logic [ADDR_PORT_W-1:0] lba,
                                        logic [HEADS_W-1:0] heads,
                                        logic [SPT_W-1:0] spt);
        longint unsigned addr_v;
        longint unsigned spt_v;
        longint unsigned per_cyl;
        longint unsigned cyl_v;
        longint unsigned rem_v;
        t_chs            chs;
        addr_v   = longint'(lba) & ((64'd1 << LBA_BITS) - 1);
        spt_v    = geometry_divisor(spt);
        per_cyl  = geometry_divisor(heads) * spt_v;
        cyl_v    = addr_v / per_cyl;
        rem_v    = addr_v % per_cyl;
        chs.cylinder = CYL_W'(cyl_v);
        chs.head     = HEADS_W'(rem_v / spt_v);
        chs.sector   = SPT_W'((rem_v % spt_v) + 1);
        chs.overflow = (cyl_v > 64'hFFFF);
        return chs;
    endfunction

    task automatic queue_lba(logic [ADDR_PORT_W-1:0] lba, int idle_pct);
        t_lba_request r;
        r.is_geometry = 1'b0;
        r.reg_sel     = REG_HEADS;
        r.reg_value   = '0;
        r.lba         = lba;
        r.idle_pct    = idle_pct;
        lba_requests.push_back(r);
    endtask

    task automatic queue_geometry(logic [CFG_DATA_W-1:0] heads_byte,
                                  logic [CFG_DATA_W-1:0] spt_byte);
        t_lba_request r;
        r.is_geometry = 1'b1;
        r.lba         = '0;
        r.idle_pct    = 0;
        r.reg_sel     = REG_HEADS;
        r.reg_value   = heads_byte;
        lba_requests.push_back(r);
        r.reg_sel     = REG_SPT;
        r.reg_value   = spt_byte;
        lba_requests.push_back(r);
    endtask

    // A geometry followed by a block of addresses, weighted towards cylinder
    // boundaries and the point where the cylinder stops fitting in 16 bits.
    task automatic queue_random_block(int count, int idle_pct,
                                      logic [CFG_DATA_W-1:0] heads_byte,
                                      logic [CFG_DATA_W-1:0] spt_byte);
        longint unsigned per_cyl;
        longint unsigned cyl_v;
        longint unsigned offset;
        longint unsigned addr_v;
        int              kind;
        per_cyl = geometry_divisor(heads_byte) *
                  geometry_divisor(longint'(spt_byte) & 64'h3F);
        queue_geometry(heads_byte, spt_byte);
        repeat (count) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                addr_v = $urandom;
            end else if (kind < 6) begin
                if ($urandom_range(0, 1))
                    cyl_v = 65535 + $urandom_range(0, 1);
                else
                    cyl_v = $urandom_range(0, 70000);
                case ($urandom_range(0, 2))
                    0: offset = 0;
                    1: offset = per_cyl - 1;
                    default: offset = $urandom % per_cyl;
                endcase
                addr_v = cyl_v * per_cyl + offset;
            end else begin
                addr_v = $urandom % (per_cyl * 65536);
            end
            queue_lba(ADDR_PORT_W'(addr_v), idle_pct);
        end
    endtask

    // Request driver: a request stays up until it has been taken; geometry
    // writes wait until every converted address has come back.
    always @(negedge i_clk) begin
        logic                    nx_start;
        logic [ADDR_PORT_W-1:0]  nx_addr;
        logic                    nx_we;
        logic [CFG_IDX_W-1:0]    nx_index;
        logic [CFG_DATA_W-1:0]   nx_data;
        nx_start = start;
        nx_addr  = i_block_address;
        nx_we    = 1'b0;
        nx_index = CFG_IDX_W'($urandom);
        nx_data  = CFG_DATA_W'($urandom);
        if (i_rst_n) begin
            if (start && request_taken)
                nx_start = 1'b0;
            if (!nx_start) begin
                nx_addr = $urandom;
                if (lba_requests.size() != 0) begin
                    if (lba_requests[0].is_geometry) begin
                        if (chs_expected.size() == 0 && !start) begin
                            nx_we    = 1'b1;
                            nx_index = lba_requests[0].reg_sel;
                            nx_data  = lba_requests[0].reg_value;
                            void'(lba_requests.pop_front());
                        end
                    end else if ($urandom_range(0, 99) >= lba_requests[0].idle_pct) begin
                        nx_start = 1'b1;
                        nx_addr  = lba_requests[0].lba;
                        void'(lba_requests.pop_front());
                    end
                end
            end
        end else begin
            nx_start = 1'b0;
        end
        start           <= nx_start;
        i_block_address <= nx_addr;
        i_cfg_we        <= nx_we;
        i_cfg_index     <= nx_index;
        i_cfg_data      <= nx_data;
    end

    // Monitor: predicts on every accepted request and checks every strobed result.
    always @(posedge i_clk) begin
        t_chs want;
        t_chs got;
        if (!i_rst_n) begin
            model_heads   <= HEADS_RESET;
            model_spt     <= SPT_RESET;
            request_taken <= 1'b0;
        end else begin
            request_taken <= start && !busy;
            if (start && !busy)
                chs_expected.push_back(lba_to_chs(i_block_address, model_heads, model_spt));
            if (i_cfg_we) begin
                if (i_cfg_index == REG_HEADS)
                    model_heads <= i_cfg_data[HEADS_W-1:0];
                else
                    model_spt <= i_cfg_data[SPT_W-1:0];
            end
            if (o_result_valid !== 1'b0) begin
                got = {o_cylinder_number, o_head_number, o_sector_number,
                       o_cylinder_overflow};
                if (chs_expected.size() == 0) begin
                    $display("%0t: result with nothing outstanding: %0d/%0d/%0d/%b",
                             $time, got.cylinder, got.head, got.sector, got.overflow);
                    mismatch_seen = 1'b1;
                end else begin
                    want = chs_expected.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected c/h/s/o %0d/%0d/%0d/%b, got %0d/%0d/%0d/%b",
                                 $time, want.cylinder, want.head, want.sector,
                                 want.overflow, got.cylinder, got.head, got.sector,
                                 got.overflow);
                        mismatch_seen = 1'b1;
                    end
                end
            end
        end
    end

    initial begin
        // Reset geometry of 16 heads and 63 sectors: first and last sectors,
        // track and cylinder edges, and the first cylinder that overflows.
        queue_lba(32'd0, 0);
        queue_lba(32'd1, 0);
        queue_lba(32'd62, 0);
        queue_lba(32'd63, 0);
        queue_lba(32'd1007, 0);
        queue_lba(32'd1008, 0);
        queue_lba(32'd66060287, 0);
        queue_lba(32'd66060288, 0);
        queue_lba(32'h5555_5555, 0);
        queue_lba(32'hAAAA_AAAA, 0);
        queue_lba(32'hFFFF_FFFF, 0);
        // Zero in both registers; the sector count only keeps the low six bits.
        queue_geometry(8'h00, 8'h40);
        queue_lba(32'd0, 0);
        queue_lba(32'd12345, 0);
        queue_lba(32'hFFFF_FFFF, 0);
        // Largest geometry.
        queue_geometry(8'hFF, 8'hFF);
        queue_lba(32'd16064, 0);
        queue_lba(32'd16065, 0);
        queue_lba(32'd1052835839, 0);
        queue_lba(32'd1052835840, 0);
        queue_lba(32'hFFFF_FFFF, 0);
        // Smallest geometry: the cylinder is the address itself.
        queue_geometry(8'h01, 8'h01);
        queue_lba(32'd65535, 0);
        queue_lba(32'd65536, 0);
        queue_lba(32'h8000_0000, 0);

        queue_random_block(78, 28, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        queue_random_block(78, 28, 8'hFF, 8'h3F);
        queue_random_block(78, 28, 8'h01, 8'h01);
        queue_random_block(78, 67, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        queue_random_block(78, 67, 8'h00, 8'hC0);
        queue_random_block(78, 67, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        queue_random_block(78, 0, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        queue_random_block(78, 0, 8'd16, 8'd63);
        queue_random_block(78, 0, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (lba_requests.size() != 0 || start || chs_expected.size() != 0)
            @(posedge i_clk);
        // Let the pipeline drain so that any stray result is seen.
        repeat (25) @(posedge i_clk);
        if (!mismatch_seen) begin
            $display("lba_to_chs_converter: match");
        end else begin
            $display("lba_to_chs_converter: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("lba_to_chs_converter: mismatch");
        $finish;
    end

endmodule
